// ===== src/qrs_pkg.sv =====
// Shared constants, types and helper functions for the quadratic root solver.
// Used by every module of the block; depends on nothing.
package qrs_pkg;

	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int OUT_W     = 34;
	localparam int CASE_W    = 3;

	localparam int PROD_W = 2 * COEF_W;
	localparam int DMAG_W = 2 * COEF_W + 2;
	localparam int SQRT_W = (DMAG_W + 2 * FRAC_BITS + 1) / 2;
	localparam int RAD_W  = 2 * SQRT_W;
	localparam int REM_W  = SQRT_W + 3;
	localparam int BASE_W = COEF_W + FRAC_BITS + 1;
	localparam int DEN_W  = COEF_W + 1;
	localparam int NUM_W  = ((COEF_W + FRAC_BITS > SQRT_W) ? COEF_W + FRAC_BITS : SQRT_W) + 2;
	localparam int NSW    = NUM_W + 1;
	localparam int SAT_A  = (NUM_W > DMAG_W) ? NUM_W : DMAG_W;
	localparam int SAT_W  = (SAT_A > OUT_W) ? SAT_A : OUT_W;

	// Three front stages, the root stages, the numerator stage, the divider
	// stages and the output register.
	localparam int LATENCY = SQRT_W + NUM_W + 5;

	localparam logic [SAT_W-1:0] SAT_MIN_MAG = SAT_W'(1) << (OUT_W - 1);
	localparam logic [SAT_W-1:0] SAT_MAX_MAG = SAT_MIN_MAG - SAT_W'(1);
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};

	typedef enum logic [CASE_W-1:0] {
		CASE_REJECT = 3'd0,
		CASE_LINEAR = 3'd1,
		CASE_NONE   = 3'd2,
		CASE_ONE    = 3'd3,
		CASE_TWO    = 3'd4
	} case_t;

	typedef struct packed {
		case_t                     rcase;
		logic signed [BASE_W-1:0]  base;
		logic [DEN_W-1:0]          den;
		logic                      den_neg;
		logic signed [OUT_W-1:0]   disc;
	} sq_tag_t;

	typedef struct packed {
		case_t                     rcase;
		logic                      neg1;
		logic                      neg2;
		logic signed [OUT_W-1:0]   disc;
	} div_tag_t;

	function automatic logic [COEF_W-1:0] mag_of(input logic [COEF_W-1:0] v);
		return v[COEF_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic neg,
			input logic [SAT_W-1:0] m);
		logic [SAT_W-1:0] nm;
		logic signed [OUT_W-1:0] r;
		nm = '0 - m;
		if (neg) begin
			r = (m > SAT_MIN_MAG) ? OUT_MIN : signed'(nm[OUT_W-1:0]);
		end else begin
			r = (m > SAT_MAX_MAG) ? OUT_MAX : signed'(m[OUT_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== src/qrs_front.sv =====
// Front end: coefficient magnitudes, the two products, the discriminant and
// case selection over three stages. Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [COEF_W-1:0] in_a,
	input  logic [COEF_W-1:0] in_b,
	input  logic [COEF_W-1:0] in_c,
	output logic              out_valid,
	output sq_tag_t           out_tag,
	output logic [RAD_W-1:0]  out_rad
);

	logic              valid_s1, valid_s2, valid_s3;
	logic [COEF_W-1:0] a_s1, b_s1, c_s1, a_s2, b_s2, c_s2;
	logic [PROD_W-1:0] bb_s2, ac_s2;
	sq_tag_t           tag_s3;
	logic [RAD_W-1:0]  rad_s3;

	logic [COEF_W-1:0] ma1, mb1, mc1, ma2, mb2;
	logic [DMAG_W-1:0] bb_x, q4, dm;
	logic              dneg;
	logic signed [BASE_W-1:0] shifted;
	sq_tag_t           tag_d;
	logic [RAD_W-1:0]  rad_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign ma1 = mag_of(a_s1);
	assign mb1 = mag_of(b_s1);
	assign mc1 = mag_of(c_s1);
	assign ma2 = mag_of(a_s2);
	assign mb2 = mag_of(b_s2);

	always_comb begin
		bb_x = DMAG_W'(bb_s2);
		q4   = DMAG_W'({ac_s2, 2'b00});
		// With a and c of opposite sign, -4ac adds to b squared.
		if (a_s2[COEF_W-1] != c_s2[COEF_W-1]) begin
			dm   = bb_x + q4;
			dneg = 1'b0;
		end else if (bb_x >= q4) begin
			dm   = bb_x - q4;
			dneg = 1'b0;
		end else begin
			dm   = q4 - bb_x;
			dneg = 1'b1;
		end

		tag_d = '0;
		if (b_s2 == '0 || c_s2 == '0) begin
			tag_d.rcase = CASE_REJECT;
		end else if (a_s2 == '0) begin
			tag_d.rcase = CASE_LINEAR;
		end else if (dneg) begin
			tag_d.rcase = CASE_NONE;
		end else if (dm == '0) begin
			tag_d.rcase = CASE_ONE;
		end else begin
			tag_d.rcase = CASE_TWO;
		end

		if (a_s2 == '0) begin
			shifted       = BASE_W'(signed'(c_s2)) <<< FRAC_BITS;
			tag_d.den     = {1'b0, mb2};
			tag_d.den_neg = b_s2[COEF_W-1];
		end else begin
			shifted       = BASE_W'(signed'(b_s2)) <<< FRAC_BITS;
			tag_d.den     = {ma2, 1'b0};
			tag_d.den_neg = a_s2[COEF_W-1];
		end
		tag_d.base = -shifted;

		if (tag_d.rcase == CASE_REJECT || tag_d.rcase == CASE_LINEAR) begin
			tag_d.disc = '0;
		end else begin
			tag_d.disc = sat_out(dneg, SAT_W'(dm));
		end

		if (tag_d.rcase == CASE_TWO) begin
			rad_d = RAD_W'({dm, {(2 * FRAC_BITS){1'b0}}});
		end else begin
			rad_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= in_a;
		b_s1   <= in_b;
		c_s1   <= in_c;
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		c_s2   <= c_s1;
		bb_s2  <= PROD_W'(mb1 * mb1);
		ac_s2  <= PROD_W'(ma1 * mc1);
		tag_s3 <= tag_d;
		rad_s3 <= rad_d;
	end

	assign out_valid = valid_s3;
	assign out_tag   = tag_s3;
	assign out_rad   = rad_s3;

endmodule

// ===== src/qrs_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with the side data
// carried alongside. Depends on qrs_pkg.
module qrs_sqrt import qrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sq_tag_t            in_tag,
	input  logic [RAD_W-1:0]   in_rad,
	output logic               out_valid,
	output sq_tag_t            out_tag,
	output logic [SQRT_W-1:0]  out_root
);

	logic              vld_s  [SQRT_W];
	sq_tag_t           tag_s  [SQRT_W];
	logic [RAD_W-1:0]  rad_s  [SQRT_W];
	logic [REM_W-1:0]  rem_s  [SQRT_W];
	logic [SQRT_W-1:0] root_s [SQRT_W];

	for (genvar i = 0; i < SQRT_W; i++) begin : g_stage
		logic              v_in;
		sq_tag_t           t_in;
		logic [RAD_W-1:0]  r_in;
		logic [REM_W-1:0]  rem_in, cur, trial;
		logic [SQRT_W-1:0] root_in;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign t_in    = in_tag;
			assign r_in    = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = vld_s[i-1];
			assign t_in    = tag_s[i-1];
			assign r_in    = rad_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		// Bring down the next two radicand bits and try the root bit as one.
		assign cur   = {rem_in[REM_W-3:0], r_in[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			tag_s[i]  <= t_in;
			rad_s[i]  <= {r_in[RAD_W-3:0], 2'b00};
			rem_s[i]  <= ge ? (cur - trial) : cur;
			root_s[i] <= {root_in[SQRT_W-2:0], ge};
		end
	end

	assign out_valid = vld_s[SQRT_W-1];
	assign out_tag   = tag_s[SQRT_W-1];
	assign out_root  = root_s[SQRT_W-1];

endmodule

// ===== src/qrs_div.sv =====
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit
// per stage, with side data carried alongside. Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  div_tag_t          in_tag,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [NUM_W-1:0]  in_dvd1,
	input  logic [NUM_W-1:0]  in_dvd2,
	output logic              out_valid,
	output div_tag_t          out_tag,
	output logic [NUM_W-1:0]  out_q1,
	output logic [NUM_W-1:0]  out_q2
);

	logic             vld_s  [NUM_W];
	div_tag_t         tag_s  [NUM_W];
	logic [DEN_W-1:0] den_s  [NUM_W];
	logic [NUM_W-1:0] dvd1_s [NUM_W];
	logic [NUM_W-1:0] dvd2_s [NUM_W];
	logic [DEN_W-1:0] rem1_s [NUM_W];
	logic [DEN_W-1:0] rem2_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic             v_in;
		div_tag_t         t_in;
		logic [DEN_W-1:0] d_in, r1_in, r2_in;
		logic [NUM_W-1:0] n1_in, n2_in;
		logic [DEN_W:0]   cur1, cur2, dx;
		logic             ge1, ge2;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign t_in  = in_tag;
			assign d_in  = in_den;
			assign n1_in = in_dvd1;
			assign n2_in = in_dvd2;
			assign r1_in = '0;
			assign r2_in = '0;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign t_in  = tag_s[k-1];
			assign d_in  = den_s[k-1];
			assign n1_in = dvd1_s[k-1];
			assign n2_in = dvd2_s[k-1];
			assign r1_in = rem1_s[k-1];
			assign r2_in = rem2_s[k-1];
		end

		assign dx   = {1'b0, d_in};
		assign cur1 = {r1_in, n1_in[NUM_W-1]};
		assign cur2 = {r2_in, n2_in[NUM_W-1]};
		assign ge1  = cur1 >= dx;
		assign ge2  = cur2 >= dx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		// Quotient bits shift in at the bottom as dividend bits leave the top.
		always_ff @(posedge clk) begin
			tag_s[k]  <= t_in;
			den_s[k]  <= d_in;
			dvd1_s[k] <= {n1_in[NUM_W-2:0], ge1};
			dvd2_s[k] <= {n2_in[NUM_W-2:0], ge2};
			rem1_s[k] <= ge1 ? DEN_W'(cur1 - dx) : DEN_W'(cur1);
			rem2_s[k] <= ge2 ? DEN_W'(cur2 - dx) : DEN_W'(cur2);
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign out_tag   = tag_s[NUM_W-1];
	assign out_q1    = dvd1_s[NUM_W-1];
	assign out_q2    = dvd2_s[NUM_W-1];

endmodule

// ===== src/quadratic_root_solver.sv =====
// Quadratic root solver: a coefficient set goes in on start, its result comes out on done.
// Throughput is one coefficient set per cycle; busy is never raised.
// The pipeline includes the 33 square-root stages and the 35 divider stages.
// Results come out on done for one cycle; the receiver cannot stall.
// Reset clears only the valid bits; data registers are not reset.
// Depends on qrs_pkg, qrs_front, qrs_sqrt and qrs_div.
module quadratic_root_solver import qrs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [COEF_W-1:0]       coef_quad,
	input  logic [COEF_W-1:0]       coef_lin,
	input  logic [COEF_W-1:0]       coef_const,
	output logic                    done,
	output logic [CASE_W-1:0]       root_case,
	output logic signed [OUT_W-1:0] root_first,
	output logic signed [OUT_W-1:0] root_second,
	output logic signed [OUT_W-1:0] disc_value
);

	logic              fr_valid, sq_valid, dv_valid;
	sq_tag_t           fr_tag, sq_tag;
	logic [RAD_W-1:0]  fr_rad;
	logic [SQRT_W-1:0] sq_root;
	div_tag_t          dv_tag;
	logic [NUM_W-1:0]  dv_q1, dv_q2;

	logic              valid_s4;
	div_tag_t          tag_s4;
	logic [DEN_W-1:0]  den_s4;
	logic [NUM_W-1:0]  dvd1_s4, dvd2_s4;

	logic                    valid_s5;
	case_t                   case_s5;
	logic signed [OUT_W-1:0] first_s5, second_s5, disc_s5;

	logic signed [NSW-1:0] base_x, s_x, n1, n2, an1, an2;
	logic [NUM_W-1:0]      half, dvd1_d, dvd2_d;
	div_tag_t              tag_d;
	logic                  two;
	logic signed [OUT_W-1:0] sat1, sat2;

	assign busy = 1'b0;

	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_a      (coef_quad),
		.in_b      (coef_lin),
		.in_c      (coef_const),
		.out_valid (fr_valid),
		.out_tag   (fr_tag),
		.out_rad   (fr_rad)
	);

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_tag    (fr_tag),
		.in_rad    (fr_rad),
		.out_valid (sq_valid),
		.out_tag   (sq_tag),
		.out_root  (sq_root)
	);

	// Numerators -b*2^F (-c*2^F if linear) plus and minus the root, as magnitudes
	// with half the divisor added so that truncating division rounds to nearest.
	always_comb begin
		two    = sq_tag.rcase == CASE_TWO;
		base_x = NSW'(sq_tag.base);
		s_x    = signed'(NSW'(sq_root));
		n1     = two ? (base_x + s_x) : base_x;
		n2     = base_x - s_x;
		an1    = n1[NSW-1] ? -n1 : n1;
		an2    = n2[NSW-1] ? -n2 : n2;
		half   = NUM_W'(sq_tag.den >> 1);
		dvd1_d = an1[NUM_W-1:0] + half;
		dvd2_d = two ? (an2[NUM_W-1:0] + half) : '0;
		tag_d.rcase = sq_tag.rcase;
		tag_d.neg1  = n1[NSW-1] ^ sq_tag.den_neg;
		tag_d.neg2  = n2[NSW-1] ^ sq_tag.den_neg;
		tag_d.disc  = sq_tag.disc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= sq_valid;
			valid_s5 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s4  <= tag_d;
		den_s4  <= sq_tag.den;
		dvd1_s4 <= dvd1_d;
		dvd2_s4 <= dvd2_d;
	end

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_tag    (tag_s4),
		.in_den    (den_s4),
		.in_dvd1   (dvd1_s4),
		.in_dvd2   (dvd2_s4),
		.out_valid (dv_valid),
		.out_tag   (dv_tag),
		.out_q1    (dv_q1),
		.out_q2    (dv_q2)
	);

	// A zero quotient stays zero whatever the signs.
	assign sat1 = sat_out(dv_tag.neg1 && dv_q1 != '0, SAT_W'(dv_q1));
	assign sat2 = sat_out(dv_tag.neg2 && dv_q2 != '0, SAT_W'(dv_q2));

	always_ff @(posedge clk) begin
		case_s5 <= dv_tag.rcase;
		disc_s5 <= dv_tag.disc;
		case (dv_tag.rcase)
			CASE_LINEAR, CASE_ONE: begin
				first_s5  <= sat1;
				second_s5 <= '0;
			end
			CASE_TWO: begin
				first_s5  <= sat1;
				second_s5 <= sat2;
			end
			default: begin
				first_s5  <= '0;
				second_s5 <= '0;
			end
		endcase
	end

	assign done        = valid_s5;
	assign root_case   = case_s5;
	assign root_first  = first_s5;
	assign root_second = second_s5;
	assign disc_value  = disc_s5;

`ifndef SYNTHESIS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result beat without a matching start");

	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (root_case == CASE_NONE || root_case == CASE_REJECT)
			|-> root_first == '0 && root_second == '0)
		else $error("roots not cleared for a case without roots");

	a_second_only_two: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_case != CASE_TWO |-> root_second == '0)
		else $error("second root set outside the two-root case");

	a_disc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (root_case == CASE_REJECT || root_case == CASE_LINEAR
			|| root_case == CASE_ONE) |-> disc_value == '0)
		else $error("discriminant not zero where it must be");
`endif

endmodule
